// File: sv/jet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants of the julia escape-time engine
// Q8.24 formats, register map, transaction payloads and sequencer states.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int PIX_W      = 10;
  localparam int COUNT_W    = 16;
  localparam int STEP_W     = 31;
  localparam int FIX_W      = 32;
  localparam int PROD_W     = 2 * FIX_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam int IMG_WIDTH_DEF  = 1024;
  localparam int IMG_HEIGHT_DEF = 1024;

  // |z|^2 bound of 4 in Q16.48
  localparam logic [PROD_W-1:0] ESCAPE_Q48 = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic [STEP_W-1:0]  RE_STEP_RST    = STEP_W'(65536);
  localparam logic [STEP_W-1:0]  IM_STEP_RST    = STEP_W'(65536);
  localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = COUNT_W'(100);

  typedef enum logic [2:0] {
    REG_RE_STEP    = 3'd0,
    REG_IM_STEP    = 3'd1,
    REG_RE_OFFSET  = 3'd2,
    REG_IM_OFFSET  = 3'd3,
    REG_CONST_RE   = 3'd4,
    REG_CONST_IM   = 3'd5,
    REG_ITER_LIMIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]       re_step;
    logic [STEP_W-1:0]       im_step;
    logic signed [FIX_W-1:0] re_offset;
    logic signed [FIX_W-1:0] im_offset;
    logic signed [FIX_W-1:0] const_re;
    logic signed [FIX_W-1:0] const_im;
    logic [COUNT_W-1:0]      iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iter_count;
    logic               escaped;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_FLUSH
  } state_e;

endpackage

// File: sv/julia_escape_time_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_top: julia set escape-time engine
// Per-pixel iteration count and escape flag in signed Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Each input transaction carries one pixel (column, row). The pixel maps to
// z0 = ((col - IMG_WIDTH/2) * re_step + re_offset,
//       (row - IMG_HEIGHT/2) * im_step + im_offset), saturated to Q8.24, and
// the engine repeats z = z*z + c while |z|^2 <= 4 and fewer than
// iteration_limit iterations are done. One output transaction returns the
// iteration count and whether |z|^2 ended above 4. All products go through a
// single registered 32x32 multiplier: the start point takes two multiplier
// passes and each iteration three (re^2, im^2, re*im) plus an update step. A
// pixel occupies the engine from acceptance through the map, square, cross,
// update and flush states until it returns to idle and the next pixel can be
// taken. The input stalls for that whole time; a finished result sits in an
// output register and does not hold off the next pixel unless a second
// result is ready while the first is still stalled. Registers sit on an apb
// port at byte addresses 4*i; write them only while the engine is idle.
// ----------------------------------------------------------------------------
module julia_escape_time_top #(
  parameter int IMG_WIDTH  = jet_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = jet_pkg::IMG_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel transactions
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  jet_pkg::pixel_t                 in_data_i,
  // result transactions
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output jet_pkg::result_t                out_data_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jet_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [jet_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [jet_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import jet_pkg::*;

  cfg_t                     cfg;
  logic signed [FIX_W-1:0]  mul_a;
  logic signed [FIX_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // register file; the user must keep it static while a pixel is in flight, the block does not enforce it
  jet_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the one shared multiplier, product valid in the cycle after the operands
  jet_mult u_mult (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // sequencer: pixel mapping, iteration loop, escape test and result register
  jet_seq #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .prod_i      (prod)
  );

endmodule

// File: sv/jet_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_cfg_regs: apb register file
// Holds steps, pan offsets, julia constant and iteration limit.
// ----------------------------------------------------------------------------
module jet_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jet_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [jet_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [jet_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output jet_pkg::cfg_t                     cfg_o
);
  import jet_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.re_step         <= RE_STEP_RST;
      cfg_q.im_step         <= IM_STEP_RST;
      cfg_q.re_offset       <= '0;
      cfg_q.im_offset       <= '0;
      cfg_q.const_re        <= '0;
      cfg_q.const_im        <= '0;
      cfg_q.iteration_limit <= ITER_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RE_STEP:    cfg_q.re_step         <= pwdata[STEP_W-1:0];
        REG_IM_STEP:    cfg_q.im_step         <= pwdata[STEP_W-1:0];
        REG_RE_OFFSET:  cfg_q.re_offset       <= $signed(pwdata);
        REG_IM_OFFSET:  cfg_q.im_offset       <= $signed(pwdata);
        REG_CONST_RE:   cfg_q.const_re        <= $signed(pwdata);
        REG_CONST_IM:   cfg_q.const_im        <= $signed(pwdata);
        REG_ITER_LIMIT: cfg_q.iteration_limit <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RE_STEP:    prdata = CFG_DATA_W'(cfg_q.re_step);
      REG_IM_STEP:    prdata = CFG_DATA_W'(cfg_q.im_step);
      REG_RE_OFFSET:  prdata = cfg_q.re_offset;
      REG_IM_OFFSET:  prdata = cfg_q.im_offset;
      REG_CONST_RE:   prdata = cfg_q.const_re;
      REG_CONST_IM:   prdata = cfg_q.const_im;
      REG_ITER_LIMIT: prdata = CFG_DATA_W'(cfg_q.iteration_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: sv/jet_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_mult: shared signed multiplier
// 32x32 signed product with one register stage at the output.
// ----------------------------------------------------------------------------
module jet_mult (
  input  logic                                 clk_i,
  input  logic signed [jet_pkg::FIX_W-1:0]     op_a_i,
  input  logic signed [jet_pkg::FIX_W-1:0]     op_b_i,
  output logic signed [jet_pkg::PROD_W-1:0]    prod_o
);
  import jet_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: sv/jet_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_seq: escape-time sequencer
// Maps the pixel, steps z = z*z + c through the shared multiplier, holds result.
// ----------------------------------------------------------------------------
module jet_seq #(
  parameter int IMG_WIDTH  = jet_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = jet_pkg::IMG_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jet_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  jet_pkg::pixel_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output jet_pkg::result_t                   out_data_o,
  output logic signed [jet_pkg::FIX_W-1:0]   mul_a_o,
  output logic signed [jet_pkg::FIX_W-1:0]   mul_b_o,
  input  logic signed [jet_pkg::PROD_W-1:0]  prod_i
);
  import jet_pkg::*;

  localparam int HalfW  = IMG_WIDTH / 2;
  localparam int HalfH  = IMG_HEIGHT / 2;
  localparam int DColW  = ((PIX_W > $clog2(IMG_WIDTH)) ? PIX_W : $clog2(IMG_WIDTH)) + 1;
  localparam int DRowW  = ((PIX_W > $clog2(IMG_HEIGHT)) ? PIX_W : $clog2(IMG_HEIGHT)) + 1;
  localparam int SumW   = PROD_W + 1;
  localparam int SqW    = PROD_W - 1;

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'({1'b0, {(FIX_W-1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_fix = {1'b0, {(FIX_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_fix = {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      sat_fix = v[FIX_W-1:0];
    end
  endfunction

  state_e                    state_q, state_d;
  logic signed [DColW-1:0]   dcol_q, dcol_d;
  logic signed [DRowW-1:0]   drow_q, drow_d;
  logic signed [FIX_W-1:0]   zr_q, zr_d;
  logic signed [FIX_W-1:0]   zi_q, zi_d;
  logic [SqW-1:0]            a_q, a_d;
  logic signed [PROD_W-1:0]  d_q, d_d;
  logic [COUNT_W-1:0]        n_q, n_d;
  logic                      esc_q, esc_d;
  logic                      out_valid_q, out_valid_d;
  result_t                   out_q, out_d;
  logic [PROD_W-1:0]         mag;
  logic                      over;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // |z|^2 from the registered re square and the square now leaving the multiplier
  assign mag  = PROD_W'(a_q) + PROD_W'(prod_i[SqW-1:0]);
  assign over = (mag > ESCAPE_Q48);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dcol_q <= dcol_d;
    drow_q <= drow_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    a_q    <= a_d;
    d_q    <= d_d;
    n_q    <= n_d;
    esc_q  <= esc_d;
    out_q  <= out_d;
  end

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MAP_RE: begin
        mul_a_o = FIX_W'(dcol_q);
        mul_b_o = $signed({1'b0, cfg_i.re_step});
      end
      ST_MAP_IM: begin
        mul_a_o = FIX_W'(drow_q);
        mul_b_o = $signed({1'b0, cfg_i.im_step});
      end
      ST_SQ_RE: begin
        mul_a_o = zr_q;
        mul_b_o = zr_q;
      end
      ST_SQ_IM: begin
        mul_a_o = zi_q;
        mul_b_o = zi_q;
      end
      default: begin
        mul_a_o = zr_q;
        mul_b_o = zi_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    dcol_d      = dcol_q;
    drow_d      = drow_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    a_d         = a_q;
    d_d         = d_q;
    n_d         = n_q;
    esc_d       = esc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dcol_d  = $signed(DColW'(in_data_i.pixel_col)) - $signed(DColW'(HalfW));
          drow_d  = $signed(DRowW'(in_data_i.pixel_row)) - $signed(DRowW'(HalfH));
          n_d     = '0;
          state_d = ST_MAP_RE;
        end
      end
      ST_MAP_RE: state_d = ST_MAP_IM;
      ST_MAP_IM: begin
        zr_d    = sat_fix(SumW'(prod_i) + SumW'(cfg_i.re_offset));
        state_d = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        if (n_q == '0) begin
          zi_d = sat_fix(SumW'(prod_i) + SumW'(cfg_i.im_offset));
        end
        state_d = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        a_d     = prod_i[SqW-1:0];
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        d_d = $signed({1'b0, a_q}) - prod_i;
        if ((n_q >= cfg_i.iteration_limit) || over) begin
          esc_d   = over;
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // floor shifts back to Q8.24, cross term doubled by the shorter shift
        zr_d    = sat_fix(SumW'(d_q >>> FRAC_BITS) + SumW'(cfg_i.const_re));
        zi_d    = sat_fix(SumW'(prod_i >>> (FRAC_BITS - 1)) + SumW'(cfg_i.const_im));
        n_d     = n_q + COUNT_W'(1);
        state_d = ST_SQ_RE;
      end
      ST_FLUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.iter_count = n_q;
          out_d.escaped    = esc_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
